// File: hw/rtl/gnce_pkg.sv
// Shared constants and helpers for the grid neighbor cell enumerator.
// Holds field widths, configuration register indexes and the offset-mask
// helpers used by the back end. No dependencies.
package gnce_pkg;

  localparam int unsigned MAX_RES_AXIS_DEF = 256;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned RES_W     = 9;
  localparam int unsigned IDX_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OFS_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RES_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RES_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RES_Z    = 3'd6;

  // Width of an effective resolution: the register is 9 bits, so it never
  // exceeds 511 whatever the axis limit.
  function automatic int unsigned res_w(input int unsigned max_res);
    int unsigned w;
    if (max_res > 511) begin
      w = RES_W;
    end else begin
      w = $clog2(max_res + 1);
      if (w < 1) begin
        w = 1;
      end
    end
    return w;
  endfunction

  // Offsets 0..2 stand for neighbor -1, 0, +1; bit o of a mask marks an
  // in-grid neighbor at offset o.
  function automatic logic [OFS_W-1:0] first_set(input logic [2:0] m);
    logic [OFS_W-1:0] r;
    if (m[0]) begin
      r = 2'd0;
    end else if (m[1]) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

  function automatic logic [OFS_W-1:0] last_set(input logic [2:0] m);
    logic [OFS_W-1:0] r;
    if (m[2]) begin
      r = 2'd2;
    end else if (m[1]) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

  function automatic logic [2:0] above(input logic [OFS_W-1:0] o);
    logic [2:0] r;
    case (o)
      2'd0:    r = 3'b110;
      2'd1:    r = 3'b100;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/grid_neighbor_cell_enumerator_unit.sv
// Top level of the 3x3x3 uniform grid neighbor cell enumerator.
// Holds the configuration registers and joins gnce_front, gnce_back and two
// gnce_fifo queues; uses gnce_pkg.
//
// For each query position (signed Q16.16) the unit finds the containing grid
// cell, origin-relative and scaled by the reciprocal cell size with
// truncation toward zero, and returns the linear index (z*res_y+y)*res_x+x
// of every in-grid cell of its 3x3x3 neighborhood, x outermost and z
// innermost, flagging the final one with last_of_run_o. A query without any
// in-grid neighbor returns one result with index_valid_o low and
// last_of_run_o high. Both sides behave as queues: push/full in, empty/pop
// out. The back end hands out one neighbor cell per cycle while the result
// queue is not full, 1 to 27 per query, and a new query is taken while
// the previous one is still being walked. On its way to the result queue a
// query passes the front stages, the neighbor walker and two index multiply
// stages. Write the configuration only while the unit is idle; writes to an
// index beyond res_z are ignored.
module grid_neighbor_cell_enumerator_unit #(
  parameter int unsigned MAX_RES_AXIS = gnce_pkg::MAX_RES_AXIS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [gnce_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [gnce_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [gnce_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [gnce_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [gnce_pkg::POS_W-1:0]    pos_z_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic        [gnce_pkg::IDX_W-1:0]    cell_index_o,
  output logic                                 index_valid_o,
  output logic                                 last_of_run_o
);

  import gnce_pkg::*;

  localparam int unsigned RW    = res_w(MAX_RES_AXIS);
  localparam int unsigned CW    = RW + 2;
  localparam int unsigned ENT_W = 3 * CW + 9;
  localparam int unsigned OUT_W = IDX_W + 2;

  // Configuration registers
  logic signed [CFG_W-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic        [CFG_W-1:0] inv_cell_q;
  logic        [RES_W-1:0] res_x_q, res_y_q, res_z_q;

  logic [RW-1:0]    res_x_eff, res_y_eff, res_z_eff;

  // Front to back queue
  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [ENT_W-1:0] mid_wdata, mid_rdata;

  // Result queue
  logic             out_push, out_full;
  logic [OUT_W-1:0] out_wdata, out_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      inv_cell_q <= 32'h0001_0000;
      res_x_q    <= RES_W'(1);
      res_y_q    <= RES_W'(1);
      res_z_q    <= RES_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X: origin_x_q <= cfg_wdata_i;
        REG_ORIGIN_Y: origin_y_q <= cfg_wdata_i;
        REG_ORIGIN_Z: origin_z_q <= cfg_wdata_i;
        REG_INV_CELL: inv_cell_q <= cfg_wdata_i;
        REG_RES_X:    res_x_q    <= cfg_wdata_i[RES_W-1:0];
        REG_RES_Y:    res_y_q    <= cfg_wdata_i[RES_W-1:0];
        REG_RES_Z:    res_z_q    <= cfg_wdata_i[RES_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp each resolution to the axis limit; zero leaves the axis empty.
  function automatic logic [RW-1:0] clamp_res(input logic [RES_W-1:0] r);
    logic [RW-1:0] v;
    if (32'(r) > 32'(MAX_RES_AXIS)) begin
      v = RW'(MAX_RES_AXIS);
    end else begin
      v = RW'(r);
    end
    return v;
  endfunction

  assign res_x_eff = clamp_res(res_x_q);
  assign res_y_eff = clamp_res(res_y_q);
  assign res_z_eff = clamp_res(res_z_q);

  gnce_front #(
    .MAX_RES_AXIS (MAX_RES_AXIS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .origin_x_i      (origin_x_q),
    .origin_y_i      (origin_y_q),
    .origin_z_i      (origin_z_q),
    .inv_cell_size_i (inv_cell_q),
    .res_x_i         (res_x_eff),
    .res_y_i         (res_y_eff),
    .res_z_i         (res_z_eff),
    .q_push_o        (mid_push),
    .q_data_o        (mid_wdata),
    .q_full_i        (mid_full)
  );

  gnce_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  gnce_back #(
    .MAX_RES_AXIS (MAX_RES_AXIS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (mid_rdata),
    .q_empty_i (mid_empty),
    .q_pop_o   (mid_pop),
    .res_x_i   (res_x_eff),
    .res_y_i   (res_y_eff),
    .o_push_o  (out_push),
    .o_data_o  (out_wdata),
    .o_full_i  (out_full)
  );

  gnce_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign cell_index_o  = out_rdata[OUT_W-1:2];
  assign index_valid_o = out_rdata[1];
  assign last_of_run_o = out_rdata[0];

  // An invalid result only ever closes a run.
  a_invalid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && !out_wdata[1]) |-> out_wdata[0])
    else $error("invalid result without last flag");

  // The walker never takes a query from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_pop && mid_empty))
    else $error("back end popped an empty queue");

  // Neither queue is pushed while full, so no transfer is lost.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_push && mid_full) && !(out_push && out_full))
    else $error("queue pushed while full");

endmodule

// File: hw/rtl/gnce_fifo.sv
// Small register queue used between the front and back end and at the
// result side. Depends on nothing; data is shown while empty_o is low.
module gnce_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/gnce_front.sv
// Front end: turns a query position into saturated cell coordinates and
// per-axis neighbor masks through its subtract and multiply stages. Uses gnce_pkg.
module gnce_front #(
  parameter int unsigned MAX_RES_AXIS = gnce_pkg::MAX_RES_AXIS_DEF,
  localparam int unsigned RW    = gnce_pkg::res_w(MAX_RES_AXIS),
  localparam int unsigned CW    = RW + 2,
  localparam int unsigned ENT_W = 3 * CW + 9
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic signed [gnce_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [gnce_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [gnce_pkg::POS_W-1:0]  pos_z_i,
  input  logic signed [gnce_pkg::CFG_W-1:0]  origin_x_i,
  input  logic signed [gnce_pkg::CFG_W-1:0]  origin_y_i,
  input  logic signed [gnce_pkg::CFG_W-1:0]  origin_z_i,
  input  logic        [gnce_pkg::CFG_W-1:0]  inv_cell_size_i,
  input  logic        [RW-1:0]               res_x_i,
  input  logic        [RW-1:0]               res_y_i,
  input  logic        [RW-1:0]               res_z_i,
  output logic                               q_push_o,
  output logic        [ENT_W-1:0]            q_data_o,
  input  logic                               q_full_i
);

  import gnce_pkg::*;

  logic [POS_W-1:0] pos_w [3];
  logic [CFG_W-1:0] org_w [3];
  logic [RW-1:0]    res_w3 [3];

  logic             adv1, adv2, accept;
  logic             s1_v_q, s1_v_d, s2_v_q, s2_v_d;

  logic [POS_W:0]   diff [3];
  logic [POS_W:0]   mag1_q [3], mag1_d [3];
  logic             neg1_q [3], neg1_d [3];
  logic [63:0]      prod [3];
  logic [31:0]      q2_q [3], q2_d [3];
  logic             neg2_q [3], neg2_d [3];

  logic [RW:0]          lim [3];
  logic signed [CW-1:0] crd [3];
  logic [CW:0]          nb [3][3];
  logic [2:0]           msk [3];

  assign pos_w[0] = pos_x_i;
  assign pos_w[1] = pos_y_i;
  assign pos_w[2] = pos_z_i;
  assign org_w[0] = origin_x_i;
  assign org_w[1] = origin_y_i;
  assign org_w[2] = origin_z_i;
  assign res_w3[0] = res_x_i;
  assign res_w3[1] = res_y_i;
  assign res_w3[2] = res_z_i;

  // Hold stage 2 while the queue is full; stage 1 then holds only if it is busy.
  assign adv2     = !s2_v_q || !q_full_i;
  assign adv1     = !s1_v_q || adv2;
  assign full_o   = !adv1;
  assign accept   = push_i && adv1;
  assign q_push_o = s2_v_q && !q_full_i;

  assign s1_v_d = adv1 ? accept : s1_v_q;
  assign s2_v_d = adv2 ? s1_v_q : s2_v_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // exact 33-bit difference, then magnitude and sign
      diff[a]   = {pos_w[a][POS_W-1], pos_w[a]} - {org_w[a][CFG_W-1], org_w[a]};
      neg1_d[a] = diff[a][POS_W];
      mag1_d[a] = diff[a][POS_W] ? (~diff[a] + 1'b1) : diff[a];
      prod[a]   = 64'(mag1_q[a]) * 64'(inv_cell_size_i);
      q2_d[a]   = prod[a][63:32];
      neg2_d[a] = neg1_q[a];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lim[a] = {1'b0, res_w3[a]} + 1'b1;
      if (neg2_q[a]) begin
        crd[a] = (q2_q[a] > 32'd2) ? CW'(-2) : -(CW'(q2_q[a][1:0]));
      end else if (q2_q[a] > 32'(lim[a])) begin
        crd[a] = CW'(lim[a]);
      end else begin
        crd[a] = CW'(q2_q[a]);
      end
      for (int o = 0; o < 3; o++) begin
        nb[a][o]  = {crd[a][CW-1], crd[a]} + (CW+1)'(o) - (CW+1)'(1);
        msk[a][o] = !nb[a][o][CW] && (nb[a][o][CW-1:0] < CW'(res_w3[a]));
      end
    end
  end

  assign q_data_o = {crd[0], crd[1], crd[2], msk[0], msk[1], msk[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (adv1) begin
        mag1_q[a] <= mag1_d[a];
        neg1_q[a] <= neg1_d[a];
      end
      if (adv2) begin
        q2_q[a]   <= q2_d[a];
        neg2_q[a] <= neg2_d[a];
      end
    end
  end

endmodule

// File: hw/rtl/gnce_back.sv
// Back end: walks the in-grid neighbors of one queued query, one per cycle if
// not stalled; two multiply stages form each linear index. Uses gnce_pkg.
module gnce_back #(
  parameter int unsigned MAX_RES_AXIS = gnce_pkg::MAX_RES_AXIS_DEF,
  localparam int unsigned RW    = gnce_pkg::res_w(MAX_RES_AXIS),
  localparam int unsigned CW    = RW + 2,
  localparam int unsigned ENT_W = 3 * CW + 9,
  localparam int unsigned OUT_W = gnce_pkg::IDX_W + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ENT_W-1:0] q_data_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic [RW-1:0]    res_x_i,
  input  logic [RW-1:0]    res_y_i,
  output logic             o_push_o,
  output logic [OUT_W-1:0] o_data_o,
  input  logic             o_full_i
);

  import gnce_pkg::*;

  logic signed [CW-1:0] qc [3];
  logic [2:0]           qm [3];

  logic                 cur_v_q, cur_v_d;
  logic signed [CW-1:0] cur_c_q [3];
  logic [2:0]           cur_m_q [3];
  logic [OFS_W-1:0]     off_q [3], off_d [3];

  logic                 adv_b, adv_c, emit, load, empty_run, is_last;
  logic [CW-1:0]        sum [3];
  logic [RW-1:0]        crd [3];

  logic                 vb_q, valb_q, lastb_q;
  logic [RW-1:0]        crdb_q [3];
  logic                 vc_q, valc_q, lastc_q;
  logic [IDX_W-1:0]     tc_q;
  logic [RW-1:0]        xc_q;
  logic [2*RW:0]        t_full;
  logic [IDX_W-1:0]     idx;

  assign {qc[0], qc[1], qc[2], qm[0], qm[1], qm[2]} = q_data_i;

  assign adv_c = !vc_q || !o_full_i;
  assign adv_b = !vb_q || adv_c;
  assign emit  = cur_v_q && adv_b;

  assign empty_run = (cur_m_q[0] == 3'b000) || (cur_m_q[1] == 3'b000) ||
                     (cur_m_q[2] == 3'b000);
  assign is_last   = empty_run ||
                     ((off_q[0] == last_set(cur_m_q[0])) &&
                      (off_q[1] == last_set(cur_m_q[1])) &&
                      (off_q[2] == last_set(cur_m_q[2])));

  // Take the next query as soon as the current run hands out its last cell.
  assign load    = !q_empty_i && (!cur_v_q || (emit && is_last));
  assign q_pop_o = load;
  assign cur_v_d = load ? 1'b1 : ((emit && is_last) ? 1'b0 : cur_v_q);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      off_d[a] = off_q[a];
    end
    if (load) begin
      for (int a = 0; a < 3; a++) begin
        off_d[a] = first_set(qm[a]);
      end
    end else if (emit && !is_last) begin
      // advance z; on wrap advance y; on wrap advance x
      if ((cur_m_q[2] & above(off_q[2])) != 3'b000) begin
        off_d[2] = first_set(cur_m_q[2] & above(off_q[2]));
      end else begin
        off_d[2] = first_set(cur_m_q[2]);
        if ((cur_m_q[1] & above(off_q[1])) != 3'b000) begin
          off_d[1] = first_set(cur_m_q[1] & above(off_q[1]));
        end else begin
          off_d[1] = first_set(cur_m_q[1]);
          off_d[0] = first_set(cur_m_q[0] & above(off_q[0]));
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = cur_c_q[a] + CW'(off_q[a]) - CW'(1);
      crd[a] = empty_run ? '0 : sum[a][RW-1:0];
    end
  end

  // (z*res_y + y), then *res_x + x, both kept modulo the index width
  assign t_full   = (2*RW+1)'(crdb_q[2]) * (2*RW+1)'(res_y_i) + (2*RW+1)'(crdb_q[1]);
  assign idx      = tc_q * IDX_W'(res_x_i) + IDX_W'(xc_q);
  assign o_data_o = {idx, valc_q, lastc_q};
  assign o_push_o = vc_q && !o_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        off_q[a] <= '0;
      end
    end else begin
      cur_v_q <= cur_v_d;
      for (int a = 0; a < 3; a++) begin
        off_q[a] <= off_d[a];
      end
      if (adv_b) begin
        vb_q <= emit;
      end
      if (adv_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int a = 0; a < 3; a++) begin
        cur_c_q[a] <= qc[a];
        cur_m_q[a] <= qm[a];
      end
    end
    if (adv_b) begin
      for (int a = 0; a < 3; a++) begin
        crdb_q[a] <= crd[a];
      end
      valb_q  <= !empty_run;
      lastb_q <= is_last;
    end
    if (adv_c) begin
      tc_q    <= IDX_W'(t_full);
      xc_q    <= crdb_q[0];
      valc_q  <= valb_q;
      lastc_q <= lastb_q;
    end
  end

endmodule
